@@ src/nlcd_pkg.sv @@
// ----------------------------------------------------------------------------
// nlcd_pkg: shared types and constants for the six-digit LCD row encoder
// Holds field widths, reciprocal constants for the decimal split and the
// digit-to-segment table.
// ----------------------------------------------------------------------------
package nlcd_pkg;

    localparam int NumW    = 32;   // input number width
    localparam int ValW    = 31;   // magnitude bits of a non-negative input
    localparam int NumPos  = 6;    // display positions
    localparam int NumRows = 4;    // segment rows
    localparam int DigW    = 4;    // one decimal digit
    localparam int SegW    = 16;   // one segment word
    localparam int RowW    = 24;   // one packed row word
    localparam int RemW    = 20;   // holds values below one million
    localparam int QHiW    = 12;   // quotient of a 31-bit value by one million

    // v / 1e6 == (v * Div1MMul) >> Div1MShift for every v below 2**31
    localparam logic [ValW-1:0] Div1MMul   = 31'd1125899907;
    localparam int              Div1MShift = 50;
    localparam logic [RemW-1:0] OneMillion = 20'd1000000;

    // x / 10 == (x * Div10Mul) >> Div10Shift for every 20-bit x
    localparam logic [RemW-1:0] Div10Mul   = 20'd838861;
    localparam int              Div10Shift = 23;

    typedef logic [NumPos-1:0][DigW-1:0] t_digits;

    // dig[k] is decimal digit k (k = 0 least significant); show[k] marks it lit
    typedef struct packed {
        logic [NumPos-1:0] show;
        t_digits           dig;
    } t_dec_word;

    function automatic logic [ValW-1:0] pow_ten(input int k);
        logic [ValW-1:0] res;
        case (k)
            0:       res = 31'd1;
            1:       res = 31'd10;
            2:       res = 31'd100;
            3:       res = 31'd1000;
            4:       res = 31'd10000;
            5:       res = 31'd100000;
            default: res = 31'd1000000;
        endcase
        return res;
    endfunction

    function automatic logic [SegW-1:0] seg_word(input logic [DigW-1:0] code);
        logic [SegW-1:0] res;
        case (code)
            4'd0:    res = 16'h1551;
            4'd1:    res = 16'h8110;
            4'd2:    res = 16'h11e1;
            4'd3:    res = 16'h1191;
            4'd4:    res = 16'h05b0;
            4'd5:    res = 16'h14b1;
            4'd6:    res = 16'h14f1;
            4'd7:    res = 16'h9004;
            4'd8:    res = 16'h15f1;
            4'd9:    res = 16'h15b1;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

@@ src/nlcd_dec_split.sv @@
// ----------------------------------------------------------------------------
// nlcd_dec_split: pipelined split of a signed number into six decimal digits
// Reduces the value modulo one million by reciprocal multiply, then peels one
// digit per stage and flags which positions are lit.
// ----------------------------------------------------------------------------
module nlcd_dec_split (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic [nlcd_pkg::NumW-1:0] i_number,
    output logic                    o_vld,
    output nlcd_pkg::t_dec_word     o_dec
);
    import nlcd_pkg::*;

    // input stage
    logic            r_a_vld;
    logic            r_a_neg;
    logic [ValW-1:0] r_a_val;

    // quotient by one million, lit flags
    logic              r_b_vld;
    logic [QHiW-1:0]   r_b_q;
    logic [ValW-1:0]   r_b_val;
    logic [NumPos-1:0] r_b_show;
    logic [2*ValW-1:0] n_b_prod;
    logic [NumPos-1:0] n_b_show;

    // remainder and digit stages: index 0 holds the remainder
    logic [RemW-1:0]   r_x  [0:NumPos-1];
    t_digits           r_dg [0:NumPos-1];
    logic [NumPos-1:0] r_sh [0:NumPos-1];
    logic              r_vl [0:NumPos-1];
    logic [ValW-1:0]   n_c_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_vl[0] <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_vl[0] <= r_b_vld;
        end
    end

    always_comb begin
        n_b_prod = (2*ValW)'(r_a_val) * (2*ValW)'(Div1MMul);
        n_b_show[0] = !r_a_neg;
        for (int k = 1; k < NumPos; k++) begin
            n_b_show[k] = !r_a_neg && (r_a_val >= pow_ten(k));
        end
    end

    always_comb begin
        n_c_rem = r_b_val - ValW'(r_b_q) * ValW'(OneMillion);
    end

    always_ff @(posedge i_clk) begin
        r_a_neg  <= i_number[NumW-1];
        r_a_val  <= i_number[ValW-1:0];
        r_b_q    <= n_b_prod[Div1MShift +: QHiW];
        r_b_val  <= r_a_val;
        r_b_show <= n_b_show;
        r_x[0]   <= n_c_rem[RemW-1:0];
        r_dg[0]  <= '0;
        r_sh[0]  <= r_b_show;
    end

    // peel one digit per stage
    for (genvar j = 0; j < NumPos-1; j++) begin : g_digit
        logic [2*RemW-1:0] n_prod;
        logic [RemW-1:0]   n_quo;
        logic [RemW-1:0]   n_rest;
        t_digits           n_dg;

        always_comb begin
            n_prod  = (2*RemW)'(r_x[j]) * (2*RemW)'(Div10Mul);
            n_quo   = RemW'(n_prod[2*RemW-1:Div10Shift]);
            n_rest  = r_x[j] - ((n_quo << 3) + (n_quo << 1));
            n_dg    = r_dg[j];
            n_dg[j] = n_rest[DigW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vl[j+1] <= 1'b0;
            end else begin
                r_vl[j+1] <= r_vl[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[j+1]  <= n_quo;
            r_dg[j+1] <= n_dg;
            r_sh[j+1] <= r_sh[j];
        end
    end

    // the last quotient is below ten and is the top digit
    always_comb begin
        o_vld              = r_vl[NumPos-1];
        o_dec.show         = r_sh[NumPos-1];
        o_dec.dig          = r_dg[NumPos-1];
        o_dec.dig[NumPos-1] = r_x[NumPos-1][DigW-1:0];
    end

endmodule

@@ src/number_to_lcd_segment_rows.sv @@
// ----------------------------------------------------------------------------
// number_to_lcd_segment_rows: six-digit segment LCD row encoder
// Converts a signed number into four packed segment-row words.
// o_valid follows a taken start through the split stages and the row register.
// Throughput: one beat per cycle; busy stays low, set by the fixed pipeline.
// Reset clears only the valid pipeline; results cannot be stalled.
// ----------------------------------------------------------------------------
module number_to_lcd_segment_rows (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [nlcd_pkg::NumW-1:0] i_number,
    output logic                      o_valid,
    output logic [nlcd_pkg::RowW-1:0] o_row0_bytes,
    output logic [nlcd_pkg::RowW-1:0] o_row1_bytes,
    output logic [nlcd_pkg::RowW-1:0] o_row2_bytes,
    output logic [nlcd_pkg::RowW-1:0] o_row3_bytes
);
    import nlcd_pkg::*;

    logic            dec_vld;
    t_dec_word       dec;
    logic            r_vld;
    logic [RowW-1:0] r_row [0:NumRows-1];
    logic [RowW-1:0] n_row [0:NumRows-1];
    logic [SegW-1:0] n_seg [0:NumPos-1];

    assign busy = 1'b0;

    nlcd_dec_split u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (start),
        .i_number (i_number),
        .o_vld    (dec_vld),
        .o_dec    (dec)
    );

    // position p shows decimal digit NumPos-1-p; row r takes nibble r from the top
    always_comb begin
        for (int p = 0; p < NumPos; p++) begin
            n_seg[p] = dec.show[NumPos-1-p] ? seg_word(dec.dig[NumPos-1-p]) : '0;
        end
        for (int r = 0; r < NumRows; r++) begin
            for (int p = 0; p < NumPos; p++) begin
                n_row[r][4*p +: 4] = n_seg[p][SegW-1-4*r -: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= dec_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < NumRows; r++) begin
            r_row[r] <= n_row[r];
        end
    end

    assign o_valid      = r_vld;
    assign o_row0_bytes = r_row[0];
    assign o_row1_bytes = r_row[1];
    assign o_row2_bytes = r_row[2];
    assign o_row3_bytes = r_row[3];

endmodule
